[sv/tree_diameter_from_parent_array_macros.svh]
`ifndef TREE_DIAMETER_FROM_PARENT_ARRAY_MACROS_SVH
`define TREE_DIAMETER_FROM_PARENT_ARRAY_MACROS_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define TDIA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tree diameter check failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define TDIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tree diameter check failed");

`endif

[sv/tdia_pkg.sv]
`default_nettype none
package tdia_pkg;
    localparam int PARENT_W = 13;
    localparam int DIAM_W = 12;
    localparam int DIST_MAX = 4095;

    typedef enum logic [12:0] {
        S_LOAD = 13'b0000000000001,
        S_CLR  = 13'b0000000000010,
        S_BR   = 13'b0000000000100,
        S_BP   = 13'b0000000001000,
        S_BW   = 13'b0000000010000,
        S_INIT = 13'b0000000100000,
        S_POP  = 13'b0000001000000,
        S_U    = 13'b0000010000000,
        S_D    = 13'b0000100000000,
        S_RP   = 13'b0001000000000,
        S_C    = 13'b0010000000000,
        S_RC   = 13'b0100000000000,
        S_FIN  = 13'b1000000000000
    } state_t;
endpackage
`default_nettype wire

[sv/tdia_ram.sv]
`default_nettype none
module tdia_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 13
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/tree_diameter_from_parent_array.sv]
// Loads a tree as a parent array, one node per transaction in index order, and
// returns its diameter in edges after the transaction flagged last_node. Loading
// takes one node per cycle. After the last node the block stalls input while it
// builds child lists (a clearing sweep, then a pass over the nodes that links each
// tree edge) and runs two breadth-first walks, each a sweep that clears the visited
// marks and then visits every reached node and its tree edges, all through
// memories that are read at one address a cycle. Nodes beyond MAX_NODES are
// dropped, and the result saturates at 4095.
`default_nettype none
module tree_diameter_from_parent_array #(
    parameter int MAX_NODES = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [tdia_pkg::PARENT_W-1:0] parent,
    input  wire logic                          last_node,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [tdia_pkg::DIAM_W-1:0]   diameter
);
    import tdia_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int CW = (NW > DIAM_W) ? NW : DIAM_W;

    state_t state_reg, state_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] head_reg, head_next;
    logic [NW-1:0] tail_reg, tail_next;
    logic          build_reg, build_next;
    logic          walk_reg, walk_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] u_reg, u_next;
    logic [AW-1:0] w_reg, w_next;
    logic [AW-1:0] p_reg, p_next;
    logic [AW:0]   c_reg, c_next;
    logic [AW-1:0] d_reg, d_next;
    logic [AW-1:0] best_reg, best_next;
    logic [AW-1:0] far_reg, far_next;
    logic          out_valid_reg, out_valid_next;
    logic [DIAM_W-1:0] diam_reg, diam_next;

    logic                pm_we, vm_we, vm_wd, dm_we, fm_we, nm_we, qm_we;
    logic [AW-1:0]       pm_wa, pm_ra, vm_wa, vm_ra, dm_wa, dm_ra, dm_wd;
    logic [AW-1:0]       fm_wa, fm_ra, nm_wa, nm_ra, qm_wa, qm_ra, qm_wd;
    logic [AW:0]         fm_wd, fm_rd, nm_wd, nm_rd;
    logic [PARENT_W-1:0] pm_wd, pm_rd;
    logic                vm_rd;
    logic [AW-1:0]       dm_rd, qm_rd;

    logic [CW-1:0] p_ext, v_ext, best_ext;
    logic [AW-1:0] v_sel;
    logic          p_ok, in_acc, reach_do;

    tdia_ram #(.DEPTH(MAX_NODES), .WIDTH(PARENT_W)) u_pmem (
        .clk(clk), .we(pm_we), .waddr(pm_wa), .wdata(pm_wd), .raddr(pm_ra), .rdata(pm_rd));
    tdia_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_vmem (
        .clk(clk), .we(vm_we), .waddr(vm_wa), .wdata(vm_wd), .raddr(vm_ra), .rdata(vm_rd));
    tdia_ram #(.DEPTH(MAX_NODES), .WIDTH(AW)) u_dmem (
        .clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(dm_wd), .raddr(dm_ra), .rdata(dm_rd));
    tdia_ram #(.DEPTH(MAX_NODES), .WIDTH(AW + 1)) u_fmem (
        .clk(clk), .we(fm_we), .waddr(fm_wa), .wdata(fm_wd), .raddr(fm_ra), .rdata(fm_rd));
    tdia_ram #(.DEPTH(MAX_NODES), .WIDTH(AW + 1)) u_nmem (
        .clk(clk), .we(nm_we), .waddr(nm_wa), .wdata(nm_wd), .raddr(nm_ra), .rdata(nm_rd));
    tdia_ram #(.DEPTH(MAX_NODES), .WIDTH(AW)) u_qmem (
        .clk(clk), .we(qm_we), .waddr(qm_wa), .wdata(qm_wd), .raddr(qm_ra), .rdata(qm_rd));

    assign in_stall  = (state_reg != S_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign diameter  = diam_reg;

    // A parent gives an edge only if it is a loaded node other than the node itself.
    assign v_sel = ((state_reg == S_BR) || (state_reg == S_BP)) ? i_reg[AW-1:0] : u_reg;
    assign p_ext = CW'(pm_rd[DIAM_W-1:0]);
    assign v_ext = CW'(v_sel);
    assign p_ok  = !pm_rd[PARENT_W-1] && (p_ext < CW'(n_reg)) && (p_ext != v_ext);
    assign best_ext = CW'(best_reg);
    assign reach_do = ((state_reg == S_RP) || (state_reg == S_RC)) && !vm_rd
                      && (tail_reg < NW'(MAX_NODES));

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        n_next = n_reg;
        i_next = i_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        build_next = build_reg;
        walk_next = walk_reg;
        start_next = start_reg;
        u_next = u_reg;
        w_next = w_reg;
        p_next = p_reg;
        c_next = c_reg;
        d_next = d_reg;
        best_next = best_reg;
        far_next = far_reg;
        out_valid_next = out_valid_reg && out_stall;
        diam_next = diam_reg;

        pm_we = 1'b0;
        pm_wa = cnt_reg[AW-1:0];
        pm_wd = parent;
        pm_ra = v_sel;
        vm_we = 1'b0;
        vm_wa = w_reg;
        vm_wd = 1'b1;
        vm_ra = w_reg;
        dm_we = 1'b0;
        dm_wa = w_reg;
        dm_wd = d_reg + AW'(1);
        dm_ra = u_reg;
        fm_we = 1'b0;
        fm_wa = p_reg;
        fm_wd = {1'b0, i_reg[AW-1:0]};
        fm_ra = u_reg;
        nm_we = 1'b0;
        nm_wa = i_reg[AW-1:0];
        nm_wd = fm_rd;
        nm_ra = c_reg[AW-1:0];
        qm_we = 1'b0;
        qm_wa = tail_reg[AW-1:0];
        qm_wd = w_reg;
        qm_ra = head_reg[AW-1:0];

        if (reach_do)
        begin
            vm_we = 1'b1;
            dm_we = 1'b1;
            qm_we = 1'b1;
            tail_next = tail_reg + NW'(1);
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_reg < NW'(MAX_NODES))
                    begin
                        pm_we = 1'b1;
                        cnt_next = cnt_reg + NW'(1);
                    end
                    if (last_node)
                    begin
                        n_next = (cnt_reg < NW'(MAX_NODES)) ? cnt_reg + NW'(1) : cnt_reg;
                        cnt_next = '0;
                        i_next = '0;
                        build_next = 1'b1;
                        walk_next = 1'b0;
                        start_next = '0;
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                vm_we = 1'b1;
                vm_wa = i_reg[AW-1:0];
                vm_wd = 1'b0;
                fm_we = build_reg;
                fm_wa = i_reg[AW-1:0];
                fm_wd = {1'b1, AW'(0)};
                i_next = i_reg + NW'(1);
                if (i_reg + NW'(1) == n_reg)
                begin
                    i_next = '0;
                    state_next = build_reg ? S_BR : S_INIT;
                end
            end
            S_BR:
            begin
                state_next = S_BP;
            end
            S_BP:
            begin
                p_next = p_ext[AW-1:0];
                fm_ra = p_ext[AW-1:0];
                if (p_ok)
                begin
                    state_next = S_BW;
                end
                else
                begin
                    i_next = i_reg + NW'(1);
                    state_next = S_BR;
                    if (i_reg + NW'(1) == n_reg)
                    begin
                        i_next = '0;
                        build_next = 1'b0;
                        state_next = S_CLR;
                    end
                end
            end
            S_BW:
            begin
                nm_we = 1'b1;
                fm_we = 1'b1;
                i_next = i_reg + NW'(1);
                state_next = S_BR;
                if (i_reg + NW'(1) == n_reg)
                begin
                    i_next = '0;
                    build_next = 1'b0;
                    state_next = S_CLR;
                end
            end
            S_INIT:
            begin
                vm_we = 1'b1;
                vm_wa = start_reg;
                dm_we = 1'b1;
                dm_wa = start_reg;
                dm_wd = '0;
                qm_we = 1'b1;
                qm_wa = '0;
                qm_wd = start_reg;
                head_next = '0;
                tail_next = NW'(1);
                best_next = '0;
                far_next = start_reg;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next = head_reg + NW'(1);
                    state_next = S_U;
                end
                else if (!walk_reg)
                begin
                    walk_next = 1'b1;
                    start_next = far_reg;
                    i_next = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_U:
            begin
                u_next = qm_rd;
                pm_ra = qm_rd;
                dm_ra = qm_rd;
                fm_ra = qm_rd;
                state_next = S_D;
            end
            S_D:
            begin
                d_next = dm_rd;
                if (dm_rd > best_reg)
                begin
                    best_next = dm_rd;
                    far_next = u_reg;
                end
                c_next = fm_rd;
                w_next = p_ext[AW-1:0];
                vm_ra = p_ext[AW-1:0];
                state_next = p_ok ? S_RP : S_C;
            end
            S_RP:
            begin
                state_next = S_C;
            end
            S_C:
            begin
                if (c_reg[AW])
                begin
                    state_next = S_POP;
                end
                else
                begin
                    w_next = c_reg[AW-1:0];
                    vm_ra = c_reg[AW-1:0];
                    state_next = S_RC;
                end
            end
            S_RC:
            begin
                c_next = nm_rd;
                state_next = S_C;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    diam_next = (best_ext > CW'(DIST_MAX)) ? DIAM_W'(DIST_MAX)
                                                           : best_ext[DIAM_W-1:0];
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg <= '0;
            n_reg <= '0;
            i_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            build_reg <= 1'b0;
            walk_reg <= 1'b0;
            best_reg <= '0;
            far_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            n_reg <= n_next;
            i_reg <= i_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            build_reg <= build_next;
            walk_reg <= walk_next;
            best_reg <= best_next;
            far_reg <= far_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        u_reg <= u_next;
        w_reg <= w_next;
        p_reg <= p_next;
        c_reg <= c_next;
        d_reg <= d_next;
        diam_reg <= diam_next;
    end
endmodule
`default_nettype wire

[sv/tdia_checker.sv]
`default_nettype none
`include "tree_diameter_from_parent_array_macros.svh"
module tdia_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic [tdia_pkg::PARENT_W-1:0] parent,
    input wire logic                          last_node,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [tdia_pkg::DIAM_W-1:0]   diameter
);
    import tdia_pkg::*;

    `TDIA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(diameter))
    `TDIA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(parent) && $stable(last_node))
    `TDIA_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && last_node, in_stall)
    `TDIA_ASSERT_SAME(a_result_after_stall, $rose(out_valid), $past(in_stall))
endmodule

bind tree_diameter_from_parent_array tdia_checker u_tdia_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .parent(parent), .last_node(last_node), .out_valid(out_valid),
    .out_stall(out_stall), .diameter(diameter));
`default_nettype wire
